@@ src/ffx_pkg.sv @@
// ----------------------------------------------------------------------------
// ffx_pkg
// Types, constants and character tables shared by the font filter block.
// ----------------------------------------------------------------------------
`default_nettype none

package ffx_pkg;

  // Request codes carried by an input item.
  typedef enum logic [1:0] {
    REQ_OPEN_READ  = 2'd0,
    REQ_OPEN_WRITE = 2'd1,
    REQ_DATA       = 2'd2,
    REQ_CLOSE      = 2'd3
  } req_e;

  // Status codes carried by a result item.
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ALREADY_OPEN = 2'd1,
    ST_NOT_OPEN     = 2'd2
  } status_e;

  // Kind of result sequence that one accepted item produces.
  typedef enum logic [1:0] {
    JOB_SINGLE = 2'd0,
    JOB_HEADER = 2'd1,
    JOB_HEX    = 2'd2
  } job_kind_e;

  // Description of the results for one item, handed to the result sequencer.
  typedef struct packed {
    job_kind_e   kind;
    logic [31:0] word;        // single: byte in [7:0]; header: strategy two in [0]
    logic        byte_valid;
    status_e     status;
  } job_t;

  localparam logic [1:0]  STRAT_ONE   = 2'd1;
  localparam logic [1:0]  STRAT_TWO   = 2'd2;
  localparam logic [16:0] ADLER_MOD   = 17'd65521;
  localparam logic [7:0]  KEY_BUMP    = 8'h10;
  localparam logic [3:0]  HEADER_LAST = 4'd15;
  localparam logic [3:0]  HEX_LAST    = 4'd7;

  // Header text: "Strategy ONE... " or "Strategy TWO... ".
  function automatic logic [7:0] header_char(input logic two, input logic [3:0] idx);
    logic [7:0] c;
    case (idx) inside
      4'd0:                c = "S";
      4'd1:                c = "t";
      4'd2:                c = "r";
      4'd3:                c = "a";
      4'd4:                c = "t";
      4'd5:                c = "e";
      4'd6:                c = "g";
      4'd7:                c = "y";
      4'd8:                c = " ";
      4'd9:                c = two ? "T" : "O";
      4'd10:               c = two ? "W" : "N";
      4'd11:               c = two ? "O" : "E";
      4'd12, 4'd13, 4'd14: c = ".";
      default:             c = " ";
    endcase
    return c;
  endfunction

  // Lower-case hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/ffx_in_if.sv @@
// ----------------------------------------------------------------------------
// ffx_in_if
// Valid/ready channel that carries one request item into the filter.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

`default_nettype wire

@@ src/ffx_out_if.sv @@
// ----------------------------------------------------------------------------
// ffx_out_if
// Valid/ready channel that carries one result item out of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input status, output ready);
endinterface

`default_nettype wire

@@ src/ffx_result_seq.sv @@
// ----------------------------------------------------------------------------
// ffx_result_seq
// Output register and sequencer: expands one job into one, eight or sixteen
// results, one per cycle while out_o is ready; frees itself on the last taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ffx_result_seq import ffx_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire job_t job_i,
  output logic      free_o,
  ffx_out_if.source out_o
);

  logic       valid_q;
  job_t       job_q;
  logic [3:0] cnt_q;
  logic       last_c;
  logic       take_c;

  // Last result of the current job.
  always_comb begin
    case (job_q.kind)
      JOB_SINGLE: last_c = 1'b1;
      JOB_HEADER: last_c = (cnt_q == HEADER_LAST);
      JOB_HEX:    last_c = (cnt_q == HEX_LAST);
      default:    last_c = 1'b1;
    endcase
  end

  assign take_c = valid_q && out_o.ready;
  assign free_o = !valid_q || (out_o.ready && last_c);

  // Control state: busy flag and position within the job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (take_c) begin
      if (last_c) begin
        valid_q <= 1'b0;
      end
      cnt_q <= cnt_q + 4'd1;
    end
  end

  // Job payload; the hex word shifts one nibble per taken item.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end else if (take_c && (job_q.kind == JOB_HEX)) begin
      job_q.word <= {job_q.word[27:0], 4'd0};
    end
  end

  // Result item fields.
  always_comb begin
    case (job_q.kind)
      JOB_SINGLE: out_o.out_byte = job_q.word[7:0];
      JOB_HEADER: out_o.out_byte = header_char(job_q.word[0], cnt_q);
      JOB_HEX:    out_o.out_byte = hex_char(job_q.word[31:28]);
      default:    out_o.out_byte = '0;
    endcase
  end

  assign out_o.valid      = valid_q;
  assign out_o.byte_valid = job_q.byte_valid;
  assign out_o.last       = last_c;
  assign out_o.status     = job_q.status;

  // A load only happens when the sequencer is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_i |-> free_o)
    else $error("job loaded while sequencer busy");

  // A loaded job shows a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_i |=> valid_q)
    else $error("loaded job produced no result");

  // A stalled multi-item job keeps its position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_q && !out_o.ready && !load_i) |=> $stable(cnt_q))
    else $error("sequencer advanced while stalled");

endmodule

`default_nettype wire

@@ src/font_filter_xor_decrypt_adler_sum.sv @@
// ----------------------------------------------------------------------------
// font_filter_xor_decrypt_adler_sum
// Output: an item's first result appears in the cycle after it is accepted.
// Throughput: one result per cycle while out_o is ready; an item causing one
// result can follow in the next cycle, an open write holds the sequencer
// for its sixteen header results and a write close for its eight hex results.
// Reset: asynchronous, active low; sessions closed, key and sums zero,
// strategy 1, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module font_filter_xor_decrypt_adler_sum import ffx_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ffx_in_if.sink     in_i,
  ffx_out_if.source  out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        read_q, read_d;
  logic        write_q, write_d;
  logic [7:0]  key_q, key_d;
  logic [15:0] low_q, low_d;
  logic [15:0] high_q, high_d;
  logic [1:0]  strat_q;

  logic        open_c;
  logic        accept_c;
  logic        seq_free;
  req_e        req_c;
  job_t        job_c;
  logic [16:0] low_sum_c, high_sum_c;
  logic [15:0] low_mod_c, high_mod_c;

  // Configuration port: strategy register, out-of-range values are ignored.
  assign pready = 1'b1;
  assign prdata = {30'd0, strat_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strat_q <= STRAT_ONE;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      if ((pwdata[1:0] == STRAT_ONE) || (pwdata[1:0] == STRAT_TWO)) begin
        strat_q <= pwdata[1:0];
      end
    end
  end

  assign req_c    = req_e'(in_i.req_type);
  assign open_c   = read_q || write_q;
  assign accept_c = in_i.valid && seq_free;
  assign in_i.ready = seq_free;

  // Checksum update: two modular adds with a conditional subtract each.
  assign low_sum_c  = {1'b0, low_q} + {9'd0, in_i.data_byte};
  assign low_mod_c  = (low_sum_c >= ADLER_MOD) ? 16'(low_sum_c - ADLER_MOD)
                                               : low_sum_c[15:0];
  assign high_sum_c = {1'b0, high_q} + {1'b0, low_mod_c};
  assign high_mod_c = (high_sum_c >= ADLER_MOD) ? 16'(high_sum_c - ADLER_MOD)
                                                : high_sum_c[15:0];

  // Request decode: next session state and the job for the sequencer.
  always_comb begin
    read_d           = read_q;
    write_d          = write_q;
    key_d            = key_q;
    low_d            = low_q;
    high_d           = high_q;
    job_c.kind       = JOB_SINGLE;
    job_c.word       = '0;
    job_c.byte_valid = 1'b0;
    job_c.status     = ST_OK;
    unique case (req_c)
      REQ_OPEN_READ, REQ_OPEN_WRITE: begin
        if (open_c) begin
          job_c.status = ST_ALREADY_OPEN;
        end else begin
          key_d = '0;
          if (req_c == REQ_OPEN_READ) begin
            read_d = 1'b1;
          end else begin
            write_d          = 1'b1;
            low_d            = {14'd0, strat_q};
            high_d           = '0;
            job_c.kind       = JOB_HEADER;
            job_c.word       = {31'd0, (strat_q == STRAT_TWO)};
            job_c.byte_valid = 1'b1;
          end
        end
      end
      REQ_DATA: begin
        if (!open_c) begin
          job_c.status = ST_NOT_OPEN;
        end else if (read_q) begin
          job_c.word       = {24'd0, in_i.data_byte ^ key_q};
          job_c.byte_valid = 1'b1;
          key_d = key_q + in_i.data_byte + ((strat_q == STRAT_TWO) ? KEY_BUMP : 8'd0);
        end else begin
          low_d  = low_mod_c;
          high_d = high_mod_c;
        end
      end
      REQ_CLOSE: begin
        if (!open_c) begin
          job_c.status = ST_NOT_OPEN;
        end else begin
          read_d  = 1'b0;
          write_d = 1'b0;
          if (write_q) begin
            job_c.kind       = JOB_HEX;
            job_c.word       = {high_q, low_q};
            job_c.byte_valid = 1'b1;
          end
        end
      end
    endcase
  end

  // Session, key and checksum state, updated on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q  <= 1'b0;
      write_q <= 1'b0;
      key_q   <= '0;
      low_q   <= '0;
      high_q  <= '0;
    end else if (accept_c) begin
      read_q  <= read_d;
      write_q <= write_d;
      key_q   <= key_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  // Result register and sequencer.
  ffx_result_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept_c),
    .job_i  (job_c),
    .free_o (seq_free),
    .out_o  (out_o)
  );

  // Never both a read and a write session.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(read_q && write_q))
    else $error("read and write sessions open together");

  // Strategy stays a legal value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (strat_q == STRAT_ONE) || (strat_q == STRAT_TWO))
    else $error("illegal strategy value");

  // A successful open write starts a write session.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept_c && (req_c == REQ_OPEN_WRITE) && !open_c) |=> write_q)
    else $error("open write did not start a session");

  // Sums stay below the modulus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ({1'b0, low_q} < ADLER_MOD) && ({1'b0, high_q} < ADLER_MOD))
    else $error("checksum out of range");

endmodule

`default_nettype wire
